// ===== sv/sfb_pkg.sv =====
// shared types, constants and helpers for the sticky round-robin flow balancer
`default_nettype none
package sfb_pkg;

   localparam int FLOW_ENTRIES_DEF = 1024;
   localparam int MAX_BACKENDS_DEF = 4;
   localparam int BACKEND_SLOTS    = 4;
   localparam int QUEUE_DEPTH      = 4;

   localparam logic [31:0] HASH_INIT  = 32'hdeadbeef + 32'd16;
   localparam logic [15:0] ETHER_IPV4 = 16'h0800;
   localparam logic [7:0]  PROTO_ICMP = 8'd1;
   localparam logic [7:0]  PROTO_TCP  = 8'd6;
   localparam logic [7:0]  PROTO_UDP  = 8'd17;
   localparam logic [15:0] LEN_IPV4   = 16'd34;
   localparam logic [15:0] LEN_TCP    = 16'd54;
   localparam logic [15:0] LEN_UDP    = 16'd42;

   localparam logic [1:0] VERDICT_PASS    = 2'd0;
   localparam logic [1:0] VERDICT_FORWARD = 2'd1;
   localparam logic [1:0] VERDICT_DROP    = 2'd2;

   localparam logic [2:0] REG_BACKEND_COUNT = 3'd0;
   localparam logic [2:0] REG_BACKEND_IP_A  = 3'd1;
   localparam logic [2:0] REG_BACKEND_IP_B  = 3'd2;
   localparam logic [2:0] REG_BACKEND_IP_C  = 3'd3;
   localparam logic [2:0] REG_BACKEND_IP_D  = 3'd4;

   // classified item handed from front to back
   typedef struct packed {
      logic        fwd;
      logic [31:0] hash;
      logic [31:0] dst;
   } entry_type;

   typedef struct packed {
      logic [2:0]                          backend_count;
      logic [BACKEND_SLOTS-1:0][31:0]      backend_ip;
   } cfg_type;

   function automatic logic [31:0] rotl(input logic [31:0] v, input int s);
      rotl = (v << s) | (v >> (32 - s));
   endfunction

endpackage
`default_nettype wire

// ===== sv/sfb_intf.sv =====
// channel interfaces for request, response and register writes
`default_nettype none
interface sfb_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] frame_bytes;
   logic [15:0] ether_kind;
   logic [7:0]  ip_proto;
   logic [31:0] source_addr;
   logic [31:0] dest_addr;
   logic [15:0] source_port_num;
   logic [15:0] dest_port_num;
   modport source (output valid, frame_bytes, ether_kind, ip_proto, source_addr, dest_addr,
                   source_port_num, dest_port_num, input ready);
   modport sink (input valid, frame_bytes, ether_kind, ip_proto, source_addr, dest_addr,
                 source_port_num, dest_port_num, output ready);
endinterface

interface sfb_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  verdict;
   logic [31:0] new_dest_addr;
   logic [1:0]  backend_slot;
   logic        flow_was_new;
   modport source (output valid, verdict, new_dest_addr, backend_slot, flow_was_new,
                   input ready);
   modport sink (input valid, verdict, new_dest_addr, backend_slot, flow_was_new,
                 output ready);
endinterface

interface sfb_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [31:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== sv/sfb_front.sv =====
// front: classifies items and runs the flow key hash over four stages
`default_nettype none
module sfb_front (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          enable,
   sfb_req_if.sink            req,
   output sfb_pkg::entry_type push_entry,
   output logic               push_valid,
   input  wire logic          push_ready
);

   typedef struct packed {
      logic        fwd;
      logic [31:0] dst;
      logic [31:0] w3;
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] c;
   } stage_type;

   stage_type stage_ff [4];
   stage_type stage_in [4];
   logic [3:0] valid_ff;
   logic [4:0] rdy;

   // classification, key words, first three mixing steps
   function automatic stage_type stage0(
      input logic [15:0] len, input logic [15:0] kind, input logic [7:0] proto,
      input logic [31:0] src, input logic [31:0] dst,
      input logic [15:0] sp_in, input logic [15:0] dp_in);
      stage_type s;
      logic ok;
      logic [15:0] sp;
      logic [15:0] dp;
      logic [31:0] w0;
      logic [31:0] w1;
      logic [31:0] w2;
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] c;
      sp = sp_in;
      dp = dp_in;
      ok = 1'b0;
      if (proto == sfb_pkg::PROTO_TCP) ok = (len >= sfb_pkg::LEN_TCP);
      else if (proto == sfb_pkg::PROTO_UDP) ok = (len >= sfb_pkg::LEN_UDP);
      else if (proto == sfb_pkg::PROTO_ICMP) begin
         ok = 1'b1;
         sp = '0;
         dp = '0;
      end
      s.fwd = ok && (kind == sfb_pkg::ETHER_IPV4) && (len >= sfb_pkg::LEN_IPV4);
      s.dst = dst;
      s.w3  = {24'd0, proto};
      w0 = {src[7:0], src[15:8], src[23:16], src[31:24]};
      w1 = {dst[7:0], dst[15:8], dst[23:16], dst[31:24]};
      w2 = {dp[7:0], dp[15:8], sp[7:0], sp[15:8]};
      a = sfb_pkg::HASH_INIT + w0;
      b = sfb_pkg::HASH_INIT + w1;
      c = sfb_pkg::HASH_INIT + w2;
      a = a - c; a = a ^ sfb_pkg::rotl(c, 4); c = c + b;
      b = b - a; b = b ^ sfb_pkg::rotl(a, 6); a = a + c;
      c = c - b; c = c ^ sfb_pkg::rotl(b, 8); b = b + a;
      s.a = a;
      s.b = b;
      s.c = c;
      return s;
   endfunction

   function automatic stage_type stage1(input stage_type s_in);
      stage_type s;
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] c;
      s = s_in;
      a = s_in.a;
      b = s_in.b;
      c = s_in.c;
      a = a - c; a = a ^ sfb_pkg::rotl(c, 16); c = c + b;
      b = b - a; b = b ^ sfb_pkg::rotl(a, 19); a = a + c;
      c = c - b; c = c ^ sfb_pkg::rotl(b, 4);  b = b + a;
      s.a = a + s_in.w3;
      s.b = b;
      s.c = c;
      return s;
   endfunction

   function automatic stage_type stage2(input stage_type s_in);
      stage_type s;
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] c;
      s = s_in;
      a = s_in.a;
      b = s_in.b;
      c = s_in.c;
      c = c ^ b; c = c - sfb_pkg::rotl(b, 14);
      a = a ^ c; a = a - sfb_pkg::rotl(c, 11);
      b = b ^ a; b = b - sfb_pkg::rotl(a, 25);
      c = c ^ b; c = c - sfb_pkg::rotl(b, 16);
      s.a = a;
      s.b = b;
      s.c = c;
      return s;
   endfunction

   function automatic stage_type stage3(input stage_type s_in);
      stage_type s;
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] c;
      s = s_in;
      a = s_in.a;
      b = s_in.b;
      c = s_in.c;
      a = a ^ c; a = a - sfb_pkg::rotl(c, 4);
      b = b ^ a; b = b - sfb_pkg::rotl(a, 14);
      c = c ^ b; c = c - sfb_pkg::rotl(b, 24);
      s.a = a;
      s.b = b;
      s.c = c;
      return s;
   endfunction

   always_comb begin
      stage_in[0] = stage0(req.frame_bytes, req.ether_kind, req.ip_proto, req.source_addr,
                           req.dest_addr, req.source_port_num, req.dest_port_num);
      stage_in[1] = stage1(stage_ff[0]);
      stage_in[2] = stage2(stage_ff[1]);
      stage_in[3] = stage3(stage_ff[2]);
   end

   always_comb begin
      rdy[4] = push_ready;
      for (int k = 3; k >= 0; k--) begin
         rdy[k] = !valid_ff[k] || rdy[k+1];
      end
   end

   assign req.ready = enable && rdy[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (rdy[0]) valid_ff[0] <= req.valid && enable;
         for (int k = 1; k < 4; k++) begin
            if (rdy[k]) valid_ff[k] <= valid_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 4; k++) begin
         if (rdy[k]) stage_ff[k] <= stage_in[k];
      end
   end

   assign push_valid      = valid_ff[3];
   assign push_entry.fwd  = stage_ff[3].fwd;
   assign push_entry.hash = stage_ff[3].c;
   assign push_entry.dst  = stage_ff[3].dst;

endmodule
`default_nettype wire

// ===== sv/sfb_queue.sv =====
// short item queue between front and back
`default_nettype none
module sfb_queue (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push_valid,
   input  wire sfb_pkg::entry_type push_entry,
   output logic               push_ready,
   output logic               pop_valid,
   output sfb_pkg::entry_type pop_entry,
   input  wire logic          pop_ready
);

   localparam int PW = $clog2(sfb_pkg::QUEUE_DEPTH);

   sfb_pkg::entry_type slot_ff [sfb_pkg::QUEUE_DEPTH];
   logic [PW-1:0] wr_ff;
   logic [PW-1:0] rd_ff;
   logic [PW:0]   count_ff;
   logic          do_push;
   logic          do_pop;

   assign push_ready = (count_ff != (PW+1)'(sfb_pkg::QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_entry  = slot_ff[rd_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (do_push) wr_ff <= wr_ff + 1'b1;
         if (do_pop) rd_ff <= rd_ff + 1'b1;
         if (do_push && !do_pop) count_ff <= count_ff + 1'b1;
         else if (!do_push && do_pop) count_ff <= count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ff] <= push_entry;
   end

endmodule
`default_nettype wire

// ===== sv/sfb_back.sv =====
// back: flow table lookup and update, backend choice and result register
`default_nettype none
module sfb_back #(
   parameter int FLOW_ENTRIES = sfb_pkg::FLOW_ENTRIES_DEF,
   parameter int MAX_BACKENDS = sfb_pkg::MAX_BACKENDS_DEF
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire sfb_pkg::cfg_type cfg,
   input  wire logic          pop_valid,
   input  wire sfb_pkg::entry_type pop_entry,
   output logic               pop_ready,
   output logic               clear_done,
   sfb_rsp_if.source          rsp
);

   localparam int IW = $clog2(FLOW_ENTRIES);

   typedef struct packed {
      logic        valid;
      logic [31:0] tag;
      logic [1:0]  slot;
   } flow_type;

   flow_type           table_mem [FLOW_ENTRIES];
   flow_type           rdata_ff;
   flow_type           byp_data_ff;
   logic               byp_ff;
   sfb_pkg::entry_type item_ff;
   logic               item_v_ff;
   logic [IW:0]        clr_ff;
   logic [1:0]         next_ff;
   logic [1:0]         next_in;

   logic               consume;
   logic               do_pop;
   logic               wr_en;
   logic [IW-1:0]      wr_addr;
   flow_type           wr_data;
   logic               mem_we;
   logic [IW-1:0]      mem_wa;
   flow_type           mem_wd;
   flow_type           cur;
   logic [2:0]         n;
   logic [1:0]         pick;
   logic [1:0]         verdict_in;
   logic [31:0]        addr_in;
   logic [1:0]         slot_in;
   logic               new_in;

   assign clear_done = clr_ff[IW];
   assign consume    = item_v_ff && (!rsp.valid || rsp.ready);
   assign pop_ready  = clear_done && (!item_v_ff || consume);
   assign do_pop     = pop_valid && pop_ready;
   assign cur        = byp_ff ? byp_data_ff : rdata_ff;
   assign wr_addr    = item_ff.hash[IW-1:0];

   always_comb begin
      n = (cfg.backend_count > 3'd4) ? 3'd4 : cfg.backend_count;
      if (int'(n) > MAX_BACKENDS) n = 3'(MAX_BACKENDS);
      pick = (({1'b0, next_ff}) >= n) ? 2'd0 : next_ff;
      verdict_in = sfb_pkg::VERDICT_PASS;
      addr_in    = item_ff.dst;
      slot_in    = 2'd0;
      new_in     = 1'b0;
      wr_en      = 1'b0;
      next_in    = next_ff;
      wr_data.valid = 1'b1;
      wr_data.tag   = item_ff.hash;
      wr_data.slot  = pick;
      if (item_ff.fwd) begin
         if (cur.valid && cur.tag == item_ff.hash) begin
            verdict_in = sfb_pkg::VERDICT_FORWARD;
            addr_in    = cfg.backend_ip[cur.slot];
            slot_in    = cur.slot;
         end else if (n == 3'd0) begin
            verdict_in = sfb_pkg::VERDICT_DROP;
         end else begin
            verdict_in = sfb_pkg::VERDICT_FORWARD;
            addr_in    = cfg.backend_ip[pick];
            slot_in    = pick;
            new_in     = 1'b1;
            wr_en      = consume;
            next_in    = (({1'b0, pick} + 3'd1) >= n) ? 2'd0 : (pick + 2'd1);
         end
      end
   end

   always_comb begin
      if (!clear_done) begin
         mem_we = 1'b1;
         mem_wa = clr_ff[IW-1:0];
         mem_wd = '0;
      end else begin
         mem_we = wr_en;
         mem_wa = wr_addr;
         mem_wd = wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) table_mem[mem_wa] <= mem_wd;
      if (do_pop) rdata_ff <= table_mem[pop_entry.hash[IW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff    <= '0;
         item_v_ff <= 1'b0;
         next_ff   <= '0;
         rsp.valid <= 1'b0;
      end else begin
         if (!clear_done) clr_ff <= clr_ff + 1'b1;
         if (do_pop) item_v_ff <= 1'b1;
         else if (consume) item_v_ff <= 1'b0;
         if (wr_en) next_ff <= next_in;
         if (consume) rsp.valid <= 1'b1;
         else if (rsp.ready) rsp.valid <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (do_pop) begin
         item_ff     <= pop_entry;
         byp_ff      <= wr_en && (wr_addr == pop_entry.hash[IW-1:0]);
         byp_data_ff <= wr_data;
      end
      if (consume) begin
         rsp.verdict       <= verdict_in;
         rsp.new_dest_addr <= addr_in;
         rsp.backend_slot  <= slot_in;
         rsp.flow_was_new  <= new_in;
      end
   end

endmodule
`default_nettype wire

// ===== sv/sticky_round_robin_flow_balancer.sv =====
// top level: register file, hash front, item queue and flow table back
// pipeline: a request passes through 4 hash stages, the queue, the table read
// and the result register; throughput one item per cycle while rsp.ready is high
// reset clears control state and then sweeps the flow table, one entry a cycle,
// over all FLOW_ENTRIES entries; req.ready stays low until the sweep ends
`default_nettype none
module sticky_round_robin_flow_balancer #(
   parameter int FLOW_ENTRIES = sfb_pkg::FLOW_ENTRIES_DEF,
   parameter int MAX_BACKENDS = sfb_pkg::MAX_BACKENDS_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   sfb_req_if.sink   req,
   sfb_rsp_if.source rsp,
   sfb_csr_if.sink   csr
);

   sfb_pkg::cfg_type   cfg_ff;
   sfb_pkg::entry_type push_entry;
   sfb_pkg::entry_type pop_entry;
   logic               push_valid;
   logic               push_ready;
   logic               pop_valid;
   logic               pop_ready;
   logic               clear_done;

   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr.valid) begin
         unique case (csr.index)
            sfb_pkg::REG_BACKEND_COUNT: cfg_ff.backend_count <= csr.data[2:0];
            sfb_pkg::REG_BACKEND_IP_A:  cfg_ff.backend_ip[0] <= csr.data;
            sfb_pkg::REG_BACKEND_IP_B:  cfg_ff.backend_ip[1] <= csr.data;
            sfb_pkg::REG_BACKEND_IP_C:  cfg_ff.backend_ip[2] <= csr.data;
            sfb_pkg::REG_BACKEND_IP_D:  cfg_ff.backend_ip[3] <= csr.data;
            default: ;
         endcase
      end
   end

   sfb_front u_front (
      .clock      (clock),
      .reset      (reset),
      .enable     (clear_done),
      .req        (req),
      .push_entry (push_entry),
      .push_valid (push_valid),
      .push_ready (push_ready)
   );

   sfb_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_entry  (pop_entry),
      .pop_ready  (pop_ready)
   );

   sfb_back #(
      .FLOW_ENTRIES (FLOW_ENTRIES),
      .MAX_BACKENDS (MAX_BACKENDS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .pop_valid  (pop_valid),
      .pop_entry  (pop_entry),
      .pop_ready  (pop_ready),
      .clear_done (clear_done),
      .rsp        (rsp)
   );

endmodule
`default_nettype wire
